// File: rtl/kls_pkg.sv
// kls_pkg: shared types, constants and character helpers for the keyword lexer
// depends on nothing; used by the channel interfaces and the lexer core

package kls_pkg;

   localparam int TEXT_CHARS_DEF = 8;
   localparam int KW_COUNT       = 7;
   localparam int KW_MAX_LEN     = 9;
   localparam int SLOT_COUNT     = 3;

   localparam logic [5:0] LEN_MAX = 6'd63;

   typedef enum logic [4:0] {
      TK_EOF       = 5'd0,
      TK_COLON     = 5'd1,
      TK_SEMI      = 5'd2,
      TK_PLUS      = 5'd3,
      TK_MINUS     = 5'd4,
      TK_STAR      = 5'd5,
      TK_SLASH     = 5'd6,
      TK_PERCENT   = 5'd7,
      TK_EQUAL     = 5'd8,
      TK_LBRACE    = 5'd9,
      TK_RBRACE    = 5'd10,
      TK_LPAREN    = 5'd11,
      TK_RPAREN    = 5'd12,
      TK_IDENT     = 5'd13,
      TK_INTEGER   = 5'd14,
      TK_KW_FLOAT  = 5'd15,
      TK_KW_FN     = 5'd16,
      TK_KW_INT    = 5'd17,
      TK_KW_NULL   = 5'd18,
      TK_KW_RETURN = 5'd19,
      TK_KW_UNDEF  = 5'd20,
      TK_KW_VAR    = 5'd21,
      TK_INVALID   = 5'd22
   } token_kind_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [63:0]    token_text;
      logic [5:0]     text_length;
      logic           text_truncated;
      logic           last_of_run;
   } token_type;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00, 8'h00},
      '{"u", "n", "d", "e", "f", "i", "n", "e", "d"},
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [5:0] KW_LEN [KW_COUNT] = '{
      6'd5, 6'd2, 6'd3, 6'd4, 6'd6, 6'd9, 6'd3
   };

   localparam token_kind_type KW_KIND [KW_COUNT] = '{
      TK_KW_FLOAT, TK_KW_FN, TK_KW_INT, TK_KW_NULL, TK_KW_RETURN, TK_KW_UNDEF,
      TK_KW_VAR
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
             (c == 8'h0D) || (c == 8'h0C);
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [5:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (pos < 6'(KW_MAX_LEN)) begin
         ch = KW_TEXT[k][pos[3:0]];
      end
      return ch;
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type kind;
      case (c)
         ":":     kind = TK_COLON;
         ";":     kind = TK_SEMI;
         "+":     kind = TK_PLUS;
         "-":     kind = TK_MINUS;
         "*":     kind = TK_STAR;
         "/":     kind = TK_SLASH;
         "%":     kind = TK_PERCENT;
         "=":     kind = TK_EQUAL;
         "{":     kind = TK_LBRACE;
         "}":     kind = TK_RBRACE;
         "(":     kind = TK_LPAREN;
         ")":     kind = TK_RPAREN;
         default: kind = TK_INVALID;
      endcase
      return kind;
   endfunction

endpackage

// File: rtl/kls_chan_if.sv
// kls_chan_if: valid/ready channels for source characters and tokens
// depends on kls_pkg

interface kls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface kls_rsp_if
   import kls_pkg::*;
   ;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [63:0] token_text;
   logic [5:0]  text_length;
   logic        text_truncated;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_text, output text_length,
                   output text_truncated, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_text, input text_length,
                 input text_truncated, input last_of_run, output ready);
endinterface

// File: rtl/keyword_lexer_stream_core.sv
// Streaming tokenizer: takes one source character per item and produces zero to three
// tokens for it (pending word, punctuation or invalid token, end of file), the last of
// them flagged with last_of_run. A character is taken in every cycle as long as the
// tokens of the previous one are gone by then: the word state and a three-slot token
// buffer are updated in the accepting cycle, and the buffer drains one token per cycle
// while the token sink is ready. Keywords are matched on the whole word; the token
// text keeps the first TEXT_CHARS characters and text_truncated marks longer words.
// depends on kls_pkg and kls_chan_if

module keyword_lexer_stream_core
   import kls_pkg::*;
#(
   parameter int TEXT_CHARS = TEXT_CHARS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kls_req_if.sink   req_chan,
   kls_rsp_if.source rsp_chan
);

   localparam int WORD_BITS = 8 * TEXT_CHARS;

   logic [WORD_BITS-1:0] word_chars_ff, word_chars_in, app_chars;
   logic [5:0]           word_count_ff, word_count_in, app_count, fw_count;
   logic                 inside_ff, inside_in;
   logic                 digit_ff, digit_in, app_digit, fw_digit;
   logic [KW_COUNT-1:0]  alive_ff, alive_in, app_alive, fw_alive;
   logic [WORD_BITS-1:0] fw_chars;

   token_type            pend_ff [SLOT_COUNT];
   token_type            pend_in [SLOT_COUNT];
   logic [1:0]           pend_cnt_ff, pend_cnt_in;

   token_type            tok_word, tok_char, tok_eof;
   token_type            slot [SLOT_COUNT];
   logic [1:0]           slot_cnt;
   token_kind_type       word_kind;
   logic                 en_word, en_char, en_eof;

   logic                 req_fire, rsp_fire;
   logic [7:0]           c;
   logic                 eot, wchar;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign c        = req_chan.char_byte;
   assign eot      = req_chan.end_of_text;
   assign wchar    = is_word_char(c);

   assign req_chan.ready = (pend_cnt_ff == 2'd0) || ((pend_cnt_ff == 2'd1) && rsp_chan.ready);

   // word state with the current character appended
   for (genvar i = 0; i < TEXT_CHARS; i++) begin : g_lane
      assign app_chars[8*i +: 8] = (word_count_ff == 6'(i)) ? c : word_chars_ff[8*i +: 8];
   end

   always_comb begin
      app_count = (word_count_ff < LEN_MAX) ? word_count_ff + 6'd1 : word_count_ff;
      app_digit = inside_ff ? digit_ff : is_digit(c);
      for (int k = 0; k < KW_COUNT; k++) begin
         app_alive[k] = alive_ff[k] && (word_count_ff < KW_LEN[k]) &&
                        (kw_char(k, word_count_ff) == c);
      end
   end

   // word that a flush would emit
   assign fw_chars = wchar ? app_chars : word_chars_ff;
   assign fw_count = wchar ? app_count : word_count_ff;
   assign fw_digit = wchar ? app_digit : digit_ff;
   assign fw_alive = wchar ? app_alive : alive_ff;

   always_comb begin
      word_kind = TK_IDENT;
      if (fw_digit) begin
         word_kind = TK_INTEGER;
      end else begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (fw_alive[k] && (fw_count == KW_LEN[k])) begin
               word_kind = KW_KIND[k];
            end
         end
      end
   end

   assign en_word = wchar ? eot : inside_ff;
   assign en_char = !wchar && !is_space(c);
   assign en_eof  = eot;

   always_comb begin
      tok_word.token_kind     = word_kind;
      tok_word.token_text     = 64'(fw_chars);
      tok_word.text_length    = fw_count;
      tok_word.text_truncated = fw_count > 6'(TEXT_CHARS);
      tok_word.last_of_run    = !en_char && !en_eof;

      tok_char.token_kind     = punct_kind(c);
      tok_char.token_text     = 64'(c);
      tok_char.text_length    = 6'd1;
      tok_char.text_truncated = 1'b0;
      tok_char.last_of_run    = !en_eof;

      tok_eof.token_kind      = TK_EOF;
      tok_eof.token_text      = '0;
      tok_eof.text_length     = 6'd0;
      tok_eof.text_truncated  = 1'b0;
      tok_eof.last_of_run     = 1'b1;
   end

   // pack present tokens to the front
   always_comb begin
      slot[0]  = tok_eof;
      slot[1]  = tok_eof;
      slot[2]  = tok_eof;
      slot_cnt = 2'd0;
      if (en_word) begin
         slot[slot_cnt] = tok_word;
         slot_cnt       = slot_cnt + 2'd1;
      end
      if (en_char) begin
         slot[slot_cnt] = tok_char;
         slot_cnt       = slot_cnt + 2'd1;
      end
      if (en_eof) begin
         slot[slot_cnt] = tok_eof;
         slot_cnt       = slot_cnt + 2'd1;
      end
   end

   always_comb begin
      word_chars_in = word_chars_ff;
      word_count_in = word_count_ff;
      inside_in     = inside_ff;
      digit_in      = digit_ff;
      alive_in      = alive_ff;
      if (req_fire) begin
         if (en_word) begin
            word_chars_in = '0;
            word_count_in = 6'd0;
            inside_in     = 1'b0;
            digit_in      = 1'b0;
            alive_in      = '1;
         end else if (wchar) begin
            word_chars_in = app_chars;
            word_count_in = app_count;
            inside_in     = 1'b1;
            digit_in      = app_digit;
            alive_in      = app_alive;
         end
      end
   end

   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      if (req_fire) begin
         pend_in     = slot;
         pend_cnt_in = slot_cnt;
      end else if (rsp_fire) begin
         pend_in[0]  = pend_ff[1];
         pend_in[1]  = pend_ff[2];
         pend_cnt_in = pend_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_chars_ff <= '0;
         word_count_ff <= 6'd0;
         inside_ff     <= 1'b0;
         digit_ff      <= 1'b0;
         alive_ff      <= '1;
         pend_cnt_ff   <= 2'd0;
      end else begin
         word_chars_ff <= word_chars_in;
         word_count_ff <= word_count_in;
         inside_ff     <= inside_in;
         digit_ff      <= digit_in;
         alive_ff      <= alive_in;
         pend_cnt_ff   <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   assign rsp_chan.valid          = pend_cnt_ff != 2'd0;
   assign rsp_chan.token_kind     = pend_ff[0].token_kind;
   assign rsp_chan.token_text     = pend_ff[0].token_text;
   assign rsp_chan.text_length    = pend_ff[0].text_length;
   assign rsp_chan.text_truncated = pend_ff[0].text_truncated;
   assign rsp_chan.last_of_run    = pend_ff[0].last_of_run;

   // an item is only taken when the buffer is empty by the next edge
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (pend_cnt_ff == 2'd0) || ((pend_cnt_ff == 2'd1) && rsp_fire))
      else $error("item accepted over pending tokens");

   // end of text always leaves a clean word state
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && eot) |=> !inside_ff && (word_count_ff == 6'd0) && (alive_ff == '1))
      else $error("word state not cleared after end of text");

   // only the final buffered token closes a run
   a_last_only_tail: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff > 2'd1) |-> !pend_ff[0].last_of_run)
      else $error("last_of_run before final token");

   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff == 2'd1) |-> pend_ff[0].last_of_run)
      else $error("final token without last_of_run");

   // a word never leaves the buffer with an empty length
   a_word_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (pend_ff[0].token_kind == TK_IDENT ||
                          pend_ff[0].token_kind == TK_INTEGER)) |->
      (pend_ff[0].text_length != 6'd0))
      else $error("word token with zero length");

endmodule

// File: bench/keyword_lexer_stream_core_checker.sv
// token checker for the keyword lexer: watches both channels, lexes each accepted
// character on its own and compares every accepted token against the oldest prediction
// depends on kls_pkg and kls_chan_if
`timescale 1ns / 1ps

module keyword_lexer_stream_core_checker
   import kls_pkg::*;
(
   input  logic clock,
   input  logic reset,
   kls_req_if   req_mon,
   kls_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   tokens_pending
);

   token_type      pending_tokens[$];
   token_kind_type keyword_kinds[string];
   string          word_text;
   int             word_len;
   bit             word_digit_first;

   initial begin
      keyword_kinds["float"]     = TK_KW_FLOAT;
      keyword_kinds["fn"]        = TK_KW_FN;
      keyword_kinds["int"]       = TK_KW_INT;
      keyword_kinds["null"]      = TK_KW_NULL;
      keyword_kinds["return"]    = TK_KW_RETURN;
      keyword_kinds["undefined"] = TK_KW_UNDEF;
      keyword_kinds["var"]       = TK_KW_VAR;
      mismatch_count = 0;
      tokens_pending = 0;
   end

   function automatic bit is_alnum(input logic [7:0] c);
      return c inside {["0":"9"], ["a":"z"], ["A":"Z"]};
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic token_kind_type symbol_kind(input logic [7:0] c);
      case (c)
         ":":     return TK_COLON;
         ";":     return TK_SEMI;
         "+":     return TK_PLUS;
         "-":     return TK_MINUS;
         "*":     return TK_STAR;
         "/":     return TK_SLASH;
         "%":     return TK_PERCENT;
         "=":     return TK_EQUAL;
         "{":     return TK_LBRACE;
         "}":     return TK_RBRACE;
         "(":     return TK_LPAREN;
         ")":     return TK_RPAREN;
         default: return TK_INVALID;
      endcase
   endfunction

   function automatic token_type take_word();
      token_type t;
      t = '0;
      t.token_kind = word_digit_first ? TK_INTEGER : TK_IDENT;
      if (!word_digit_first && keyword_kinds.exists(word_text)) begin
         t.token_kind = keyword_kinds[word_text];
      end
      for (int i = 0; i < TEXT_CHARS_DEF && i < word_text.len(); i++) begin
         t.token_text[8*i +: 8] = word_text[i];
      end
      t.text_length    = (word_len > int'(LEN_MAX)) ? LEN_MAX : 6'(word_len);
      t.text_truncated = (word_len > TEXT_CHARS_DEF);
      word_text        = "";
      word_len         = 0;
      word_digit_first = 1'b0;
      return t;
   endfunction

   function automatic void lex_char(input logic [7:0] c, input logic eot);
      token_type run[$];
      token_type t;
      if (is_alnum(c)) begin
         if (word_len == 0) begin
            word_digit_first = c inside {["0":"9"]};
         end
         // longer words never match a keyword, so the tail is not kept
         if (word_len < 16) begin
            word_text = $sformatf("%s%c", word_text, c);
         end
         word_len++;
      end else begin
         if (word_len != 0) begin
            run.push_back(take_word());
         end
         if (!is_blank(c)) begin
            t = '0;
            t.token_kind  = symbol_kind(c);
            t.token_text  = 64'(c);
            t.text_length = 6'd1;
            run.push_back(t);
         end
      end
      if (eot) begin
         if (word_len != 0) begin
            run.push_back(take_word());
         end
         t = '0;
         t.token_kind = TK_EOF;
         run.push_back(t);
      end
      if (run.size() != 0) begin
         run[run.size() - 1].last_of_run = 1'b1;
      end
      foreach (run[i]) begin
         pending_tokens.push_back(run[i]);
      end
   endfunction

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         pending_tokens.delete();
         word_text        = "";
         word_len         = 0;
         word_digit_first = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            lex_char(req_mon.char_byte, req_mon.end_of_text);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.token_kind     = token_kind_type'(rsp_mon.token_kind);
            got.token_text     = rsp_mon.token_text;
            got.text_length    = rsp_mon.text_length;
            got.text_truncated = rsp_mon.text_truncated;
            got.last_of_run    = rsp_mon.last_of_run;
            if (pending_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%t unexpected token: kind %0d text %h len %0d trunc %b last %b",
                           $realtime, got.token_kind, got.token_text, got.text_length,
                           got.text_truncated, got.last_of_run);
               end
            end else begin
               want = pending_tokens.pop_front();
               if (got.token_kind !== want.token_kind || got.token_text !== want.token_text ||
                   got.text_length !== want.text_length ||
                   got.text_truncated !== want.text_truncated ||
                   got.last_of_run !== want.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%t token mismatch: expected kind %0d text %h len %0d trunc %b last %b",
                              $realtime, want.token_kind, want.token_text, want.text_length,
                              want.text_truncated, want.last_of_run);
                     $display("%t                 got      kind %0d text %h len %0d trunc %b last %b",
                              $realtime, got.token_kind, got.token_text, got.text_length,
                              got.text_truncated, got.last_of_run);
                  end
               end
            end
         end
      end
      tokens_pending = pending_tokens.size();
   end

endmodule

// File: bench/keyword_lexer_stream_core_tb.sv
// top of the keyword lexer bench: clock, reset, source text and token back-pressure,
// a stall watchdog and the final verdict
// depends on kls_chan_if, keyword_lexer_stream_core and keyword_lexer_stream_core_checker
`timescale 1ns / 1ps

module keyword_lexer_stream_core_tb;

   localparam int STALL_LIMIT = 1000;
   localparam int TEXT_ITEMS  = 210;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } source_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   tokens_pending;

   source_char_type source_text[$];
   string        punct_chars     = ":;+-*/%={}()";
   string        keyword_words[7] = '{"float", "fn", "int", "null", "return", "undefined", "var"};
   logic [7:0]   blank_chars[6]   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   kls_req_if req_chan ();
   kls_rsp_if rsp_chan ();

   keyword_lexer_stream_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   keyword_lexer_stream_core_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   function automatic void push_char(input logic [7:0] c, input logic eot);
      source_text.push_back({c, eot});
   endfunction

   function automatic bit random_eot();
      return $urandom_range(0, 39) == 0;
   endfunction

   function automatic void push_word(input string w);
      for (int i = 0; i < w.len(); i++) begin
         push_char(w[i], random_eot());
      end
   endfunction

   function automatic logic [7:0] random_alnum(input bit letter_only);
      int pick;
      pick = letter_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
      if (pick < 26) begin
         return 8'("a" + pick);
      end else if (pick < 52) begin
         return 8'("A" + pick - 26);
      end
      return 8'("0" + pick - 52);
   endfunction

   function automatic void build_source_text();
      string w;
      int    pick;
      // control byte, top byte, every punctuation character
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      for (int i = 0; i < punct_chars.len(); i++) begin
         push_char(punct_chars[i], 1'b0);
      end
      push_char("f", 1'b0);
      push_char("n", 1'b0);
      push_char(8'h09, 1'b0);
      // integer ended by a symbol that also ends the text
      push_char("7", 1'b0);
      push_char("a", 1'b0);
      push_char("(", 1'b1);
      push_char("v", 1'b0);
      push_char("a", 1'b0);
      push_char("r", 1'b1);
      push_char(" ", 1'b1);
      // long word: saturated length and truncated text
      w = $sformatf("%c", random_alnum(1));
      repeat (65) w = $sformatf("%s%c", w, random_alnum(0));
      push_word(w);
      push_char(" ", 1'b0);
      while (source_text.size() < TEXT_ITEMS) begin
         pick = $urandom_range(0, 99);
         w = "";
         if (pick < 25) begin
            w = keyword_words[$urandom_range(0, 6)];
         end else if (pick < 35) begin
            w = keyword_words[$urandom_range(0, 6)];
            if ($urandom_range(0, 1) != 0) begin
               w = $sformatf("%s%c", w, random_alnum(0));
            end else begin
               w = w.substr(0, w.len() - 2);
            end
         end else if (pick < 50) begin
            w = $sformatf("%c", random_alnum(1));
            repeat ($urandom_range(0, 11)) w = $sformatf("%s%c", w, random_alnum(0));
         end else if (pick < 62) begin
            w = $sformatf("%c", 8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 9)) begin
               if ($urandom_range(0, 3) == 0) begin
                  w = $sformatf("%s%c", w, random_alnum(0));
               end else begin
                  w = $sformatf("%s%c", w, 8'("0" + $urandom_range(0, 9)));
               end
            end
         end else if (pick < 82) begin
            push_char(punct_chars[$urandom_range(0, 11)], random_eot());
         end else if (pick < 93) begin
            push_char(blank_chars[$urandom_range(0, 5)], random_eot());
         end else begin
            push_char(8'($urandom_range(0, 255)), random_eot());
         end
         if (w.len() != 0) begin
            push_word(w);
            if ($urandom_range(0, 4) != 0) begin
               if ($urandom_range(0, 1) != 0) begin
                  push_char(blank_chars[$urandom_range(0, 5)], random_eot());
               end else begin
                  push_char(punct_chars[$urandom_range(0, 11)], random_eot());
               end
            end
         end
      end
      source_text[source_text.size() - 1].eot = 1'b1;
   endfunction

   initial begin
      int gap;
      int calm;
      req_chan.valid       = 1'b0;
      req_chan.char_byte   = 8'h00;
      req_chan.end_of_text = 1'b0;
      calm = 0;
      build_source_text();
      wait (reset == 1'b0);
      foreach (source_text[i]) begin
         if (calm > 0) begin
            gap = 0;
            calm--;
         end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 14) == 0) begin
               calm = $urandom_range(8, 24);
            end
         end
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_chan.valid       = 1'b1;
         req_chan.char_byte   = source_text[i].ch;
         req_chan.end_of_text = source_text[i].eot;
         do @(posedge clock); while (!req_chan.ready);
         @(negedge clock);
      end
      req_chan.valid = 1'b0;
      while (tokens_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int  gap;
      int  calm;
      int  taken;
      bit  held;
      rsp_chan.ready = 1'b0;
      calm  = 0;
      taken = 0;
      held  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!held && taken >= 30) begin
            gap  = 80;
            held = 1'b1;
         end else if (calm > 0) begin
            gap = 0;
            calm--;
         end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 14) == 0) begin
               calm = $urandom_range(8, 24);
            end
         end
         if (gap != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
rtl/kls_pkg.sv
rtl/kls_chan_if.sv
rtl/keyword_lexer_stream_core.sv
bench/keyword_lexer_stream_core_checker.sv
bench/keyword_lexer_stream_core_tb.sv
